/* hdl/unaligned_word_copy_realigner_macros.svh */
// Assertion macros shared by the realigner checks.
`ifndef UNALIGNED_WORD_COPY_REALIGNER_MACROS_SVH
`define UNALIGNED_WORD_COPY_REALIGNER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define UWCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define UWCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check what reset leaves behind, so reset is the cause and not a disable.
`define UWCR_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/uwcr_pkg.sv */
package uwcr_pkg;

   localparam int LANES               = 8;
   localparam int BYTE_BITS           = 8;
   localparam int DATA_BITS           = LANES * BYTE_BITS;
   localparam int BUF_BITS            = 2 * DATA_BITS;
   localparam int LANE_BITS           = 3;
   localparam int COUNT_BITS          = 4;
   localparam int INDEX_BITS          = 14;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_OFFSET = 2'd0,
      CSR_DST_OFFSET = 2'd1,
      CSR_LENGTH     = 2'd2
   } csr_index_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [LANE_BITS-1:0]  lane_type;

   // One source word after trimming: valid bytes packed from lane 0.
   typedef struct packed {
      logic [DATA_BITS-1:0] data;
      count_type            count;
      logic                 done;
   } entry_type;

   typedef struct packed {
      logic     arm;
      lane_type dst_offset;
   } ctrl_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] word_index;
      logic [DATA_BITS-1:0]  write_data;
      logic [LANES-1:0]      byte_enable;
      logic                  last;
   } result_type;

   // Enable the lowest count lanes.
   function automatic logic [LANES-1:0] lane_enables(count_type count);
      logic [LANES-1:0] en;
      for (int i = 0; i < LANES; i++) begin
         en[i] = (count_type'(i) < count);
      end
      return en;
   endfunction

   // Widen a lane enable into a bit mask.
   function automatic logic [DATA_BITS-1:0] byte_mask(logic [LANES-1:0] en);
      logic [DATA_BITS-1:0] m;
      for (int i = 0; i < LANES; i++) begin
         m[i*BYTE_BITS +: BYTE_BITS] = {BYTE_BITS{en[i]}};
      end
      return m;
   endfunction

endpackage

/* hdl/uwcr_req_if.sv */
interface uwcr_req_if;
   logic                           valid;
   logic                           ready;
   logic [uwcr_pkg::DATA_BITS-1:0] src_word;

   modport source (output valid, output src_word, input ready);
   modport sink (input valid, input src_word, output ready);
endinterface

/* hdl/uwcr_rsp_if.sv */
interface uwcr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [uwcr_pkg::INDEX_BITS-1:0] word_index;
   logic [uwcr_pkg::DATA_BITS-1:0]  write_data;
   logic [uwcr_pkg::LANES-1:0]      byte_enable;
   logic                            last;

   modport source (output valid, output word_index, output write_data,
                   output byte_enable, output last, input ready);
   modport sink (input valid, input word_index, input write_data,
                 input byte_enable, input last, output ready);
endinterface

/* hdl/uwcr_front.sv */
module uwcr_front #(
   parameter int LENGTH_BITS = uwcr_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [uwcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LENGTH_BITS-1:0]              csr_write_data,
   input  logic                                accept,
   input  logic [uwcr_pkg::DATA_BITS-1:0]      in_word,
   output logic                                push,
   output uwcr_pkg::entry_type                 push_entry,
   output uwcr_pkg::ctrl_type                  ctrl
);

   uwcr_pkg::lane_type  src_offset_ff, src_offset_in;
   uwcr_pkg::lane_type  dst_offset_ff, dst_offset_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                first_pending_ff, first_pending_in;

   logic                arm;
   uwcr_pkg::lane_type  skip;
   uwcr_pkg::count_type avail;
   uwcr_pkg::count_type take;
   logic [uwcr_pkg::DATA_BITS-1:0] shifted;

   // Register decode; any known register write re-arms the copy
   always_comb begin
      arm           = 1'b0;
      src_offset_in = src_offset_ff;
      dst_offset_in = dst_offset_ff;
      length_in     = length_ff;
      if (csr_write_enable) begin
         case (uwcr_pkg::csr_index_type'(csr_index))
            uwcr_pkg::CSR_SRC_OFFSET: begin
               arm           = 1'b1;
               src_offset_in = csr_write_data[uwcr_pkg::LANE_BITS-1:0];
            end
            uwcr_pkg::CSR_DST_OFFSET: begin
               arm           = 1'b1;
               dst_offset_in = csr_write_data[uwcr_pkg::LANE_BITS-1:0];
            end
            uwcr_pkg::CSR_LENGTH: begin
               arm       = 1'b1;
               length_in = csr_write_data;
            end
            default: begin
               arm = 1'b0;
            end
         endcase
      end
   end

   // Trim the source word: drop leading bytes on the first word, trailing past the end
   always_comb begin
      skip    = first_pending_ff ? src_offset_ff : '0;
      avail   = uwcr_pkg::count_type'(uwcr_pkg::LANES) - {1'b0, skip};
      take    = (bytes_left_ff < LENGTH_BITS'(avail))
                ? bytes_left_ff[uwcr_pkg::COUNT_BITS-1:0] : avail;
      shifted = in_word >> (int'(skip) * uwcr_pkg::BYTE_BITS);

      push            = accept && (bytes_left_ff != '0) && !arm;
      push_entry.data  = shifted & uwcr_pkg::byte_mask(uwcr_pkg::lane_enables(take));
      push_entry.count = take;
      push_entry.done  = (bytes_left_ff == LENGTH_BITS'(take));

      bytes_left_in    = bytes_left_ff;
      first_pending_in = first_pending_ff;
      if (arm) begin
         bytes_left_in    = length_in;
         first_pending_in = 1'b1;
      end else if (push) begin
         bytes_left_in    = bytes_left_ff - LENGTH_BITS'(take);
         first_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_offset_ff    <= '0;
         dst_offset_ff    <= '0;
         length_ff        <= '0;
         bytes_left_ff    <= '0;
         first_pending_ff <= 1'b1;
      end else begin
         src_offset_ff    <= src_offset_in;
         dst_offset_ff    <= dst_offset_in;
         length_ff        <= length_in;
         bytes_left_ff    <= bytes_left_in;
         first_pending_ff <= first_pending_in;
      end
   end

   assign ctrl.arm        = arm;
   assign ctrl.dst_offset = dst_offset_ff;

endmodule

/* hdl/uwcr_queue.sv */
module uwcr_queue #(
   parameter int DEPTH = uwcr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                flush,
   input  logic                push,
   input  uwcr_pkg::entry_type push_entry,
   input  logic                pop,
   output uwcr_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   uwcr_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);

endmodule

/* hdl/uwcr_back.sv */
module uwcr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  uwcr_pkg::ctrl_type   ctrl,
   input  uwcr_pkg::entry_type  head,
   input  logic                 empty,
   output logic                 pop,
   input  logic                 out_ready,
   output logic                 out_valid,
   output uwcr_pkg::result_type out_result
);

   // Byte buffer: carried bytes packed from lane 0, clean above the count
   logic [uwcr_pkg::BUF_BITS-1:0] buf_ff, buf_in;
   uwcr_pkg::count_type           cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic                          dst_first_ff, dst_first_in;
   logic [uwcr_pkg::INDEX_BITS-1:0] index_ff, index_in;
   logic                          valid_ff, valid_in;
   uwcr_pkg::result_type          result_ff, result_in;

   uwcr_pkg::lane_type            lane;
   uwcr_pkg::count_type           need;
   logic                          slot_free;
   logic                          buf_ready;
   logic [uwcr_pkg::BUF_BITS-1:0] cur_buf;
   uwcr_pkg::count_type           cur_cnt;
   logic                          cur_done;
   logic                          emit;
   uwcr_pkg::count_type           w;
   logic [uwcr_pkg::BUF_BITS-1:0] rem_buf;
   uwcr_pkg::count_type           rem_cnt;

   always_comb begin
      lane      = dst_first_ff ? ctrl.dst_offset : '0;
      need      = uwcr_pkg::count_type'(uwcr_pkg::LANES) - {1'b0, lane};
      slot_free = !valid_ff || out_ready;
      buf_ready = (cnt_ff >= need) || (done_ff && (cnt_ff != '0));

      // Merge the next entry only when the buffer cannot fill a word on its own
      pop = !buf_ready && !empty && slot_free && !ctrl.arm;

      cur_buf  = buf_ff;
      cur_cnt  = cnt_ff;
      cur_done = done_ff;
      if (pop) begin
         cur_buf  = buf_ff | (uwcr_pkg::BUF_BITS'(head.data)
                    << (int'(cnt_ff[uwcr_pkg::LANE_BITS-1:0]) * uwcr_pkg::BYTE_BITS));
         cur_cnt  = cnt_ff + head.count;
         cur_done = head.done;
      end

      emit    = slot_free && !ctrl.arm
                && ((cur_cnt >= need) || (cur_done && (cur_cnt != '0)));
      w       = (cur_cnt < need) ? cur_cnt : need;
      rem_buf = cur_buf >> (int'(w) * uwcr_pkg::BYTE_BITS);
      rem_cnt = cur_cnt - w;

      result_in.word_index  = index_ff;
      result_in.write_data  = (cur_buf[uwcr_pkg::DATA_BITS-1:0]
                               & uwcr_pkg::byte_mask(uwcr_pkg::lane_enables(w)))
                              << (int'(lane) * uwcr_pkg::BYTE_BITS);
      result_in.byte_enable = uwcr_pkg::lane_enables(w) << lane;
      result_in.last        = cur_done && (rem_cnt == '0);

      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      dst_first_in = dst_first_ff;
      index_in     = index_ff;
      if (ctrl.arm) begin
         buf_in       = '0;
         cnt_in       = '0;
         done_in      = 1'b0;
         dst_first_in = 1'b1;
         index_in     = '0;
      end else if (emit) begin
         buf_in       = rem_buf;
         cnt_in       = rem_cnt;
         done_in      = cur_done && (rem_cnt != '0);
         dst_first_in = 1'b0;
         index_in     = index_ff + 1'b1;
      end else if (pop) begin
         buf_in  = cur_buf;
         cnt_in  = cur_cnt;
         done_in = cur_done;
      end

      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         dst_first_ff <= 1'b1;
         index_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         dst_first_ff <= dst_first_in;
         index_ff     <= index_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* hdl/unaligned_word_copy_realigner.sv */
// Byte-lane realigner for an unaligned 64-bit word copy, little-endian lanes.
// Program src_offset (index 0), dst_offset (index 1) and length_bytes (index 2)
// on the csr_ port; every write to one of these registers re-arms the copy with the current values.
// Then feed the aligned source words on req_channel, ceil((src_offset+length)/8)
// of them; any word beyond that is taken and dropped. rsp_channel gives masked
// destination word writes: relative word_index, write_data with disabled lanes
// zero, byte_enable and last on the final write. A length of zero gives nothing.
// An accepted word passes through the queue and then the output register.
// Throughput: one source word per cycle while the queue has room and one write
// per cycle while the receiver is ready; the back end merges at most one queued
// word into its byte buffer and emits one write per cycle. A copy gives one
// write more than it takes source words at most; that extra write comes at the
// tail and does not hold the input. A stalled receiver holds the output register,
// then fills the four-entry queue and req_channel.ready drops; nothing is lost.
// Reset (synchronous) clears the registers, carry and queue, sets both first-word
// flags and leaves no copy armed.
module unaligned_word_copy_realigner #(
   parameter int LENGTH_BITS = uwcr_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = uwcr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   uwcr_req_if.sink                            req_channel,
   uwcr_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [uwcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LENGTH_BITS-1:0]              csr_write_data
);

   uwcr_pkg::ctrl_type   ctrl;
   uwcr_pkg::entry_type  push_entry;
   uwcr_pkg::entry_type  head;
   uwcr_pkg::result_type result;
   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 full;
   logic                 empty;
   logic                 out_valid;

   // Take an item whenever the queue has room, even while a write waits
   assign req_channel.ready = !full;
   assign accept            = req_channel.valid && req_channel.ready;

   // Front: register decode, source trimming and byte count
   uwcr_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .in_word          (req_channel.src_word),
      .push             (push),
      .push_entry       (push_entry),
      .ctrl             (ctrl)
   );

   // Queue of trimmed words; drop its contents on re-arm
   uwcr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .flush      (ctrl.arm),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   // Back: carry buffer, destination lane placement and output register
   uwcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .out_ready  (rsp_channel.ready),
      .out_valid  (out_valid),
      .out_result (result)
   );

   assign rsp_channel.valid       = out_valid;
   assign rsp_channel.word_index  = result.word_index;
   assign rsp_channel.write_data  = result.write_data;
   assign rsp_channel.byte_enable = result.byte_enable;
   assign rsp_channel.last        = result.last;

endmodule

/* hdl/uwcr_checker.sv */
`include "unaligned_word_copy_realigner_macros.svh"

module uwcr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [uwcr_pkg::INDEX_BITS-1:0]   rsp_word_index,
   input logic [uwcr_pkg::DATA_BITS-1:0]    rsp_write_data,
   input logic [uwcr_pkg::LANES-1:0]        rsp_byte_enable,
   input logic                              rsp_last
);

   logic [uwcr_pkg::DATA_BITS-1:0] enabled_bits;

   assign enabled_bits = uwcr_pkg::byte_mask(rsp_byte_enable);

   `UWCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word_index) && $stable(rsp_write_data) && $stable(rsp_byte_enable) && $stable(rsp_last), "write changed while stalled")
   `UWCR_ASSERT_NOW(a_lanes_present, clock, reset, rsp_valid, rsp_byte_enable != '0, "write with no lanes enabled")
   `UWCR_ASSERT_NOW(a_disabled_zero, clock, reset, rsp_valid, (rsp_write_data & ~enabled_bits) == '0, "data in disabled lane")
   `UWCR_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid, "write shown after reset")

endmodule

bind unaligned_word_copy_realigner uwcr_checker u_uwcr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_channel.valid),
   .rsp_ready       (rsp_channel.ready),
   .rsp_word_index  (rsp_channel.word_index),
   .rsp_write_data  (rsp_channel.write_data),
   .rsp_byte_enable (rsp_channel.byte_enable),
   .rsp_last        (rsp_channel.last)
);
